### src/dsh_pkg.sv
// Package for the descriptive statistics histogram block.
// Holds payload structs, widths and the front-to-back queue entry type.
// No dependencies.
`default_nettype none
package dsh_pkg;
    localparam int MAX_ITEMS  = 65536;
    localparam int CNT_W      = 17;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 48;
    localparam int VAL_W      = 16;

    typedef struct packed {
        logic [15:0] value;
        logic        has_value;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [23:0] mean_q8;
        logic [15:0] min_nonzero;
        logic [15:0] max_value;
        logic [15:0] variation_q8;
        logic [16:0] frac_zero_q16;
        logic [16:0] frac_one_q16;
        logic [16:0] frac_two_q16;
        logic [16:0] frac_many_q16;
        logic [16:0] item_total;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] s;
        logic [SQ_W-1:0]  q;
        logic [15:0]      mn;
        logic [15:0]      mx;
        logic [CNT_W-1:0] b0;
        logic [CNT_W-1:0] b1;
        logic [CNT_W-1:0] b2;
        logic [CNT_W-1:0] b3;
    } snap_t;
endpackage
`default_nettype wire

### src/dsh_front.sv
// Front part: accumulates statistics one value per cycle unless a finished snapshot still waits.
// Emits a snapshot on the closing item. Depends on dsh_pkg.
`default_nettype none
module dsh_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dsh_pkg::in_item_t in_data,
    output logic                 snap_valid,
    input  wire logic            snap_ready,
    output dsh_pkg::snap_t       snap_data
);
    dsh_pkg::snap_t acc_reg, acc_next;
    dsh_pkg::snap_t snap_reg;
    logic           full_reg, full_next;
    logic [dsh_pkg::VAL_W-1:0] v;
    logic [31:0]    sq;
    logic           take;

    assign in_ready  = !full_reg || snap_ready;
    assign v         = in_data.value;
    assign sq        = {16'd0, v} * {16'd0, v};
    assign take      = in_valid && in_ready;
    assign full_next = (full_reg && !snap_ready) || (take && in_data.last);

    always_comb begin
        acc_next = acc_reg;
        if (in_data.has_value && acc_reg.n < dsh_pkg::CNT_W'(dsh_pkg::MAX_ITEMS)) begin
            acc_next.n = acc_reg.n + 1'b1;
            acc_next.s = acc_reg.s + dsh_pkg::SUM_W'(v);
            acc_next.q = acc_reg.q + {16'd0, sq};
            if (v != 16'd0 && (acc_reg.mn == 16'd0 || v < acc_reg.mn)) acc_next.mn = v;
            if (v > acc_reg.mx) acc_next.mx = v;
            if (v == 16'd0)      acc_next.b0 = acc_reg.b0 + 1'b1;
            else if (v == 16'd1) acc_next.b1 = acc_reg.b1 + 1'b1;
            else if (v == 16'd2) acc_next.b2 = acc_reg.b2 + 1'b1;
            else                 acc_next.b3 = acc_reg.b3 + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
            if (take) begin
                if (in_data.last) begin
                    acc_reg  <= '0;
                    snap_reg <= acc_next;
                end else begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    assign snap_valid = full_reg;
    assign snap_data  = snap_reg;
endmodule
`default_nettype wire

### src/dsh_back.sv
// Back part: sequencer for the divisions and square root of one list.
// Shares one restoring divider and one bit-serial root unit. Depends on dsh_pkg.
`default_nettype none
module dsh_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              snap_valid,
    output logic                   snap_ready,
    input  wire dsh_pkg::snap_t    snap_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dsh_pkg::out_item_t     m_data
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_NQ = 4'd1, ST_S2 = 4'd2, ST_SUB = 4'd3,
        ST_SQRT = 4'd4, ST_DIV = 4'd5, ST_STORE = 4'd6, ST_OUT = 4'd7, ST_MUL = 4'd8;

    logic [3:0]        st_reg;
    dsh_pkg::snap_t    sn_reg;
    logic [2:0]        job_reg;
    logic [6:0]        bit_reg;
    logic [5:0]        pp_reg;
    logic [95:0]       acc_reg;
    logic [95:0]       nq_reg;
    logic [81:0]       d_reg;
    logic [81:0]       rem_reg;
    logic [40:0]       root_reg;
    logic [47:0]       num_reg;
    logic [31:0]       den_reg;
    logic [47:0]       quo_reg;
    logic [32:0]       drem_reg;
    dsh_pkg::out_item_t res_reg;

    logic [83:0] tr;
    logic [83:0] rem_sh;
    logic [32:0] dr_sh;
    logic [47:0] mul_a;
    logic [15:0] mul_b;
    logic [63:0] pprod;

    assign snap_ready = (st_reg == ST_IDLE);
    assign m_valid    = (st_reg == ST_OUT);
    assign m_data     = res_reg;

    assign rem_sh = {rem_reg, d_reg[81:80]};
    assign tr     = {41'd0, root_reg, 2'b01};
    assign dr_sh  = {drem_reg[31:0], num_reg[47]};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (st_reg == ST_NQ) begin
            mul_a = sn_reg.q;
            mul_b = {15'd0, sn_reg.n[16]} & 16'hFFFF;
            mul_b = (pp_reg[0]) ? {15'd0, sn_reg.n[16]} : sn_reg.n[15:0];
        end else begin
            mul_a = {16'd0, sn_reg.s};
            mul_b = pp_reg[0] ? sn_reg.s[31:16] : sn_reg.s[15:0];
        end
        pprod = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            unique case (st_reg)
                ST_IDLE: if (snap_valid) begin
                    sn_reg  <= snap_data;
                    res_reg <= '0;
                    job_reg <= 3'd0;
                    st_reg  <= (snap_data.n == '0) ? ST_OUT : ST_DIV;
                    num_reg <= {8'd0, snap_data.s, 8'd0};
                    den_reg <= 32'(snap_data.n);
                    quo_reg <= '0;
                    drem_reg <= '0;
                    bit_reg <= 7'd48;
                end
                ST_DIV: begin
                    if (bit_reg != 7'd0) begin
                        num_reg  <= num_reg << 1;
                        if (dr_sh >= {1'b0, den_reg}) begin
                            drem_reg <= dr_sh - {1'b0, den_reg};
                            quo_reg  <= {quo_reg[46:0], 1'b1};
                        end else begin
                            drem_reg <= dr_sh;
                            quo_reg  <= {quo_reg[46:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 1'b1;
                    end else begin
                        st_reg <= ST_STORE;
                    end
                end
                ST_STORE: begin
                    unique case (job_reg)
                        3'd0: res_reg.mean_q8       <= quo_reg[23:0];
                        3'd1: res_reg.frac_zero_q16 <= quo_reg[16:0];
                        3'd2: res_reg.frac_one_q16  <= quo_reg[16:0];
                        3'd3: res_reg.frac_two_q16  <= quo_reg[16:0];
                        3'd4: res_reg.frac_many_q16 <= quo_reg[16:0];
                        default: res_reg.variation_q8 <=
                            (quo_reg[47:16] != '0) ? 16'hFFFF : quo_reg[15:0];
                    endcase
                    quo_reg  <= '0;
                    drem_reg <= '0;
                    bit_reg  <= 7'd48;
                    den_reg  <= 32'(sn_reg.n);
                    job_reg  <= job_reg + 1'b1;
                    unique case (job_reg)
                        3'd0: begin
                            num_reg <= {15'd0, sn_reg.b0, 16'd0};
                            st_reg  <= ST_DIV;
                        end
                        3'd1: begin
                            num_reg <= {15'd0, sn_reg.b1, 16'd0};
                            st_reg  <= ST_DIV;
                        end
                        3'd2: begin
                            num_reg <= {15'd0, sn_reg.b2, 16'd0};
                            st_reg  <= ST_DIV;
                        end
                        3'd3: begin
                            num_reg <= {15'd0, sn_reg.b3, 16'd0};
                            st_reg  <= ST_DIV;
                        end
                        3'd4: begin
                            if (sn_reg.s == '0) begin
                                st_reg <= ST_OUT;
                            end else begin
                                acc_reg <= '0;
                                pp_reg  <= '0;
                                st_reg  <= ST_NQ;
                            end
                        end
                        default: st_reg <= ST_OUT;
                    endcase
                    res_reg.min_nonzero <= sn_reg.mn;
                    res_reg.max_value   <= sn_reg.mx;
                    res_reg.item_total  <= sn_reg.n;
                end
                ST_NQ: begin
                    if (pp_reg[0]) begin
                        nq_reg <= acc_reg + (96'(pprod) << 16);
                        acc_reg <= '0;
                        pp_reg <= '0;
                        st_reg <= ST_S2;
                    end else begin
                        acc_reg <= 96'(pprod);
                        pp_reg  <= 6'd1;
                    end
                end
                ST_S2: begin
                    if (pp_reg[0]) begin
                        acc_reg <= acc_reg + (96'(pprod) << 16);
                        st_reg  <= ST_SUB;
                    end else begin
                        acc_reg <= 96'(pprod);
                        pp_reg  <= 6'd1;
                    end
                end
                ST_SUB: begin
                    if (acc_reg > nq_reg) begin
                        d_reg <= '0;
                    end else begin
                        d_reg <= 82'((nq_reg - acc_reg) << 16);
                    end
                    rem_reg  <= '0;
                    root_reg <= '0;
                    bit_reg  <= 7'd41;
                    st_reg   <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (bit_reg != 7'd0) begin
                        d_reg <= d_reg << 2;
                        if (rem_sh >= tr) begin
                            rem_reg  <= 82'(rem_sh - tr);
                            root_reg <= {root_reg[39:0], 1'b1};
                        end else begin
                            rem_reg  <= 82'(rem_sh);
                            root_reg <= {root_reg[39:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 1'b1;
                    end else begin
                        st_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    num_reg  <= {7'd0, root_reg};
                    den_reg  <= sn_reg.s;
                    quo_reg  <= '0;
                    drem_reg <= '0;
                    bit_reg  <= 7'd48;
                    st_reg   <= ST_DIV;
                end
                ST_OUT: if (m_ready) st_reg <= ST_IDLE;
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/dsh_queue.sv
// Two-entry queue between front and back parts.
// Depends on dsh_pkg.
`default_nettype none
module dsh_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire dsh_pkg::snap_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output dsh_pkg::snap_t      rd_data
);
    dsh_pkg::snap_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_valid && wr_ready) begin
                mem_reg[wp_reg] <= wr_data;
                wp_reg <= ~wp_reg;
            end
            if (rd_valid && rd_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((wr_valid && wr_ready)) - 2'((rd_valid && rd_ready));
        end
    end
endmodule
`default_nettype wire

### src/descriptive_stats_histogram.sv
// Top level of the descriptive statistics histogram block.
// Instantiates dsh_front, dsh_queue and dsh_back; uses dsh_pkg.
//
//  channel | direction | payload             | handshake
//  s_      | in        | dsh_pkg::in_item_t  | s_valid / s_ready
//  m_      | out       | dsh_pkg::out_item_t | m_valid / m_ready
//
// One value per cycle is accumulated unless the front is stalled; a closing item's
// snapshot is registered and passed on. The back sequencer takes a new list only
// when idle (six divisions each followed by a store step, four multiply steps, a root,
// a subtract and a setup step); only five divisions when the sum is zero, none if empty.
// The queue holds two closed lists; the input stalls only when front and queue are full.
// Reset is synchronous, active low, and empties all control state.
`default_nettype none
module descriptive_stats_histogram (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dsh_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dsh_pkg::out_item_t      m_data
);
    logic f_valid, f_ready, q_valid, q_ready;
    dsh_pkg::snap_t f_data, q_data;

    dsh_front u_front (.aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .in_data(s_data), .snap_valid(f_valid), .snap_ready(f_ready), .snap_data(f_data));
    dsh_queue u_queue (.aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data(f_data), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));
    dsh_back u_back (.aclk, .aresetn, .snap_valid(q_valid), .snap_ready(q_ready),
        .snap_data(q_data), .m_valid, .m_ready, .m_data);
endmodule
`default_nettype wire

### src/dsh_checker.sv
// Port checker for descriptive_stats_histogram, bound to the top level.
// Depends on dsh_pkg.
`default_nettype none
module dsh_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire dsh_pkg::out_item_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
    a_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.min_nonzero != 16'd0 |-> m_data.min_nonzero <= m_data.max_value)
        else $error("min above max");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.item_total == 17'd0 |-> m_data.mean_q8 == 24'd0)
        else $error("empty list mean");
endmodule
bind descriptive_stats_histogram dsh_checker u_chk (.*);
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for descriptive_stats_histogram: directed table, then random lists.
// Holds its own list-statistics predictor and a queue of expected results; depends on dsh_pkg.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    dsh_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    dsh_pkg::out_item_t m_data;

    descriptive_stats_histogram u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    typedef struct {
        dsh_pkg::in_item_t  item;
        bit                 typed;
        dsh_pkg::out_item_t stats;
    } row_t;

    dsh_pkg::out_item_t stats_q[$];
    row_t      rows[$];
    int        errs;
    int        s_idle;
    int        m_idle;

    logic [16:0] acc_n;
    logic [31:0] acc_s;
    logic [47:0] acc_q;
    logic [15:0] acc_min;
    logic [15:0] acc_max;
    logic [16:0] acc_bin[4];

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic flag(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errs++;
    endtask

    function automatic logic [63:0] int_sqrt(logic [127:0] d);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= d) root = cand;
        end
        return root;
    endfunction

    function automatic logic [15:0] variation_of();
        logic [127:0] nq;
        logic [127:0] s2;
        logic [63:0]  ratio;
        if (acc_s == 0) return '0;
        nq = 128'(acc_n) * 128'(acc_q);
        s2 = 128'(acc_s) * 128'(acc_s);
        if (s2 > nq) return '0;
        ratio = int_sqrt((nq - s2) << 16) / 64'(acc_s);
        return (ratio > 64'd65535) ? 16'hffff : ratio[15:0];
    endfunction

    function automatic dsh_pkg::out_item_t list_stats();
        dsh_pkg::out_item_t r;
        logic [63:0] t;
        r = '0;
        if (acc_n != 0) begin
            t = (64'(acc_s) << 8) / 64'(acc_n);
            r.mean_q8 = t[23:0];
            r.min_nonzero = acc_min;
            r.max_value = acc_max;
            r.variation_q8 = variation_of();
            t = (64'(acc_bin[0]) << 16) / 64'(acc_n);
            r.frac_zero_q16 = t[16:0];
            t = (64'(acc_bin[1]) << 16) / 64'(acc_n);
            r.frac_one_q16 = t[16:0];
            t = (64'(acc_bin[2]) << 16) / 64'(acc_n);
            r.frac_two_q16 = t[16:0];
            t = (64'(acc_bin[3]) << 16) / 64'(acc_n);
            r.frac_many_q16 = t[16:0];
            r.item_total = acc_n;
        end
        return r;
    endfunction

    task automatic clear_lists();
        acc_n = '0;
        acc_s = '0;
        acc_q = '0;
        acc_min = '0;
        acc_max = '0;
        for (int i = 0; i < 4; i++) acc_bin[i] = '0;
    endtask

    task automatic absorb(dsh_pkg::in_item_t it, bit typed, dsh_pkg::out_item_t given);
        logic [15:0] v;
        v = it.value;
        if (it.has_value && acc_n < dsh_pkg::MAX_ITEMS) begin
            acc_n = acc_n + 1'b1;
            acc_s = acc_s + 32'(v);
            acc_q = acc_q + 48'(v) * 48'(v);
            if (v != 0 && (acc_min == 0 || v < acc_min)) acc_min = v;
            if (v > acc_max) acc_max = v;
            acc_bin[(v > 2) ? 3 : v[1:0]]++;
        end
        if (it.last) begin
            stats_q = {stats_q, (typed ? given : list_stats())};
            clear_lists();
        end
    endtask

    task automatic send(dsh_pkg::in_item_t it, bit typed, dsh_pkg::out_item_t given);
        @(negedge aclk);
        while ($urandom_range(99) < s_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        do @(posedge aclk); while (!s_ready);
        absorb(it, typed, given);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (stats_q.size() != 0) @(posedge aclk);
    endtask

    function automatic dsh_pkg::in_item_t rand_item(int close_pct);
        dsh_pkg::in_item_t it;
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) it.value = 16'($urandom_range(3));
        else if (sel < 38) it.value = 16'hffff;
        else it.value = 16'($urandom);
        it.has_value = ($urandom_range(99) < 92);
        it.last = ($urandom_range(99) < close_pct);
        return it;
    endfunction

    task automatic add_row(logic [15:0] v, bit h, bit l, bit typed, dsh_pkg::out_item_t given);
        row_t r;
        r.item = '{value: v, has_value: h, last: l};
        r.typed = typed;
        r.stats = given;
        rows = {rows, r};
    endtask

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= m_idle);
    end

    always @(posedge aclk) begin
        dsh_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stats_q.size() == 0) begin
                flag("unexpected result", 0, 0);
            end else begin
                want = stats_q.pop_front();
                if (m_data.mean_q8 != want.mean_q8)
                    flag("mean_q8", m_data.mean_q8, want.mean_q8);
                if (m_data.min_nonzero != want.min_nonzero)
                    flag("min_nonzero", m_data.min_nonzero, want.min_nonzero);
                if (m_data.max_value != want.max_value)
                    flag("max_value", m_data.max_value, want.max_value);
                if (m_data.variation_q8 != want.variation_q8)
                    flag("variation_q8", m_data.variation_q8, want.variation_q8);
                if (m_data.frac_zero_q16 != want.frac_zero_q16)
                    flag("frac_zero_q16", m_data.frac_zero_q16, want.frac_zero_q16);
                if (m_data.frac_one_q16 != want.frac_one_q16)
                    flag("frac_one_q16", m_data.frac_one_q16, want.frac_one_q16);
                if (m_data.frac_two_q16 != want.frac_two_q16)
                    flag("frac_two_q16", m_data.frac_two_q16, want.frac_two_q16);
                if (m_data.frac_many_q16 != want.frac_many_q16)
                    flag("frac_many_q16", m_data.frac_many_q16, want.frac_many_q16);
                if (m_data.item_total != want.item_total)
                    flag("item_total", m_data.item_total, want.item_total);
            end
        end
    end

    initial begin
        dsh_pkg::out_item_t z;
        dsh_pkg::out_item_t e;
        dsh_pkg::in_item_t  it;
        int        sent;
        errs = 0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        s_idle = 34;
        m_idle = 78;
        clear_lists();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        z = '0;
        add_row(16'h0000, 1'b0, 1'b1, 1'b1, z);
        e = z;
        e.mean_q8 = 24'd16776960; e.min_nonzero = 16'hffff; e.max_value = 16'hffff;
        e.frac_many_q16 = 17'd65536; e.item_total = 17'd1;
        add_row(16'hffff, 1'b1, 1'b1, 1'b1, e);
        e = z;
        e.frac_zero_q16 = 17'd65536; e.item_total = 17'd1;
        add_row(16'h0000, 1'b1, 1'b1, 1'b1, e);
        e = z;
        e.mean_q8 = 24'd256; e.min_nonzero = 16'd1; e.max_value = 16'd1;
        e.frac_one_q16 = 17'd65536; e.item_total = 17'd1;
        add_row(16'h0001, 1'b1, 1'b1, 1'b1, e);
        e = z;
        e.mean_q8 = 24'd512; e.min_nonzero = 16'd2; e.max_value = 16'd2;
        e.frac_two_q16 = 17'd65536; e.item_total = 17'd1;
        add_row(16'h0002, 1'b1, 1'b1, 1'b1, e);
        add_row(16'hffff, 1'b0, 1'b0, 1'b0, z);
        add_row(16'h0003, 1'b1, 1'b0, 1'b0, z);
        add_row(16'h0000, 1'b1, 1'b0, 1'b0, z);
        add_row(16'h0001, 1'b1, 1'b0, 1'b0, z);
        add_row(16'h0002, 1'b1, 1'b0, 1'b0, z);
        add_row(16'hffff, 1'b1, 1'b1, 1'b0, z);
        add_row(16'h0000, 1'b1, 1'b0, 1'b0, z);
        add_row(16'h0000, 1'b1, 1'b0, 1'b0, z);
        add_row(16'h1234, 1'b0, 1'b1, 1'b0, z);
        add_row(16'h5555, 1'b1, 1'b0, 1'b0, z);
        add_row(16'haaaa, 1'b1, 1'b1, 1'b0, z);
        add_row(16'd100, 1'b1, 1'b0, 1'b0, z);
        add_row(16'd100, 1'b1, 1'b1, 1'b0, z);
        add_row(16'h0001, 1'b1, 1'b0, 1'b0, z);
        add_row(16'hffff, 1'b1, 1'b1, 1'b0, z);
        foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].stats);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            s_idle = (ph == 0) ? 34 : (ph == 1) ? 78 : 0;
            m_idle = (ph == 0) ? 78 : (ph == 1) ? 34 : 0;
            sent = 0;
            while (sent < 477) begin
                it = rand_item(($urandom_range(9) == 0) ? 50 : 14);
                send(it, 1'b0, z);
                sent++;
                if (it.last && $urandom_range(19) == 0) drain();
            end
            drain();
        end

        repeat (400) @(posedge aclk);
        if (errs == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
